// ===== rtl/bmi_pkg.sv =====
// ----------------------------------------------------------------------------
// Package for the 3x3 block matrix inverse
// Widths, transaction types and the cofactor index table that the datapath
// uses.
// ----------------------------------------------------------------------------
package bmi_pkg;

    localparam int DW   = 32;          // data width of one entry
    localparam int FB   = 16;          // fraction bits
    localparam int NENT = 9;           // entries in one 3x3 block
    localparam int AW   = 2 * DW + 1;  // adjugate entry, signed
    localparam int DETW = 3 * DW + 3;  // determinant, signed
    localparam int RW   = DETW + 1;    // divider partial remainder
    localparam int QB   = DW + 1;      // quotient bits before saturation
    localparam int QW   = QB + 1;      // quotient after rounding
    localparam int NW   = AW + 2 * FB; // shifted numerator magnitude
    localparam int XW   = NW + RW;     // common width for the range compare

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } bmi_in_t;

    typedef struct packed {
        logic signed [DW-1:0] r00;
        logic signed [DW-1:0] r01;
        logic signed [DW-1:0] r02;
        logic signed [DW-1:0] r10;
        logic signed [DW-1:0] r11;
        logic signed [DW-1:0] r12;
        logic signed [DW-1:0] r20;
        logic signed [DW-1:0] r21;
        logic signed [DW-1:0] r22;
        logic                 singular;
    } bmi_out_t;

    // Adjugate entry k is a[p]*a[q] - a[r]*a[s], entries in row-major order.
    localparam logic [3:0] ADJ_IDX [NENT][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

// ===== rtl/block_3x3_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// 3x3 block matrix inverse
// Cofactor inverse of one signed Q16.16 3x3 block per transaction, with a
// bit-per-stage restoring divider, round to nearest and saturation.
// ----------------------------------------------------------------------------
// An accepted transaction passes through QB + 9 register stages to its result in the output
// register, the first one loaded by the accepting edge; the depth is set by the
// 33 quotient bits of the divider.
// Throughput: one transaction per cycle; every stage advances independently,
// so bubbles collapse and a stalled output only holds the stages behind it.
// Reset clears the stage valid bits only; payload registers are not reset.
module block_3x3_matrix_inverse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mat_valid,
    output logic              mat_stall,
    input  bmi_pkg::bmi_in_t  mat_data,
    output logic              inv_valid,
    input  logic              inv_stall,
    output bmi_pkg::bmi_out_t inv_data
);
    import bmi_pkg::*;

    // Stage map: 0 cofactor products, 1 adjugate, 2 determinant partial
    // products, 3 partial sums, 4 determinant, 5 magnitudes, 6 range check
    // and divider seed, 7 .. 6+QB divider steps, 7+QB rounding, 8+QB output.
    localparam int NST   = QB + 9;
    localparam int S_DIV = 6;
    localparam int S_RND = 7 + QB;
    localparam int S_OUT = 8 + QB;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    logic signed [DW-1:0] a [NENT];

    // Handshake: a stage loads when it is empty or when the stage after it
    // loads as well.
    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || !inv_stall;
        for (int i = NST - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign mat_stall = !adv[0];
    assign inv_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= mat_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign a[0] = mat_data.m00;
    assign a[1] = mat_data.m01;
    assign a[2] = mat_data.m02;
    assign a[3] = mat_data.m10;
    assign a[4] = mat_data.m11;
    assign a[5] = mat_data.m12;
    assign a[6] = mat_data.m20;
    assign a[7] = mat_data.m21;
    assign a[8] = mat_data.m22;

    // Stage 0: the eighteen 2x2 minor products, plus the first row, which the
    // determinant expansion needs later.
    logic signed [2*DW-1:0] prod_reg [NENT][2];
    logic signed [DW-1:0]   row0_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < NENT; k++)
            begin
                prod_reg[k][0] <= a[ADJ_IDX[k][0]] * a[ADJ_IDX[k][1]];
                prod_reg[k][1] <= a[ADJ_IDX[k][2]] * a[ADJ_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++)
            begin
                row0_reg[j] <= a[j];
            end
        end
    end

    // Stage 1: adjugate entries, exact.
    logic signed [AW-1:0] adj1_reg [NENT];
    logic signed [DW-1:0] row1_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < NENT; k++)
            begin
                adj1_reg[k] <= AW'(prod_reg[k][0]) - AW'(prod_reg[k][1]);
            end
            row1_reg <= row0_reg;
        end
    end

    // Stage 2: the determinant is the first row times the first column of
    // the adjugate. Each adjugate entry is split into a low unsigned word and
    // a high signed part so that every multiplier stays about DW by DW.
    logic signed [2*DW:0] plo_reg [3];
    logic signed [2*DW:0] phi_reg [3];
    logic signed [AW-1:0] adj2_reg [NENT];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= row1_reg[j] * $signed({1'b0, adj1_reg[3*j][DW-1:0]});
                phi_reg[j] <= row1_reg[j] * $signed(adj1_reg[3*j][AW-1:DW]);
            end
            adj2_reg <= adj1_reg;
        end
    end

    // Stage 3: recombine the split products.
    logic signed [DETW-1:0] term_reg [3];
    logic signed [AW-1:0]   adj3_reg [NENT];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= (DETW'(phi_reg[j]) <<< DW) + DETW'(plo_reg[j]);
            end
            adj3_reg <= adj2_reg;
        end
    end

    // Stage 4: determinant.
    logic signed [DETW-1:0] det_reg;
    logic signed [AW-1:0]   adj4_reg [NENT];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj4_reg <= adj3_reg;
        end
    end

    // Stage 5: sign and magnitude. The divider works on magnitudes and the
    // sign of each result is the sign of its adjugate entry times that of the
    // determinant.
    logic [DETW-1:0] dmag5_reg;
    logic [AW-1:0]   amag_reg [NENT];
    logic [NENT-1:0] neg5_reg;
    logic            zero5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            dmag5_reg <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
            zero5_reg <= (det_reg == '0);
            for (int k = 0; k < NENT; k++)
            begin
                amag_reg[k] <= adj4_reg[k][AW-1] ? AW'(-adj4_reg[k]) : AW'(adj4_reg[k]);
                neg5_reg[k] <= adj4_reg[k][AW-1] ^ det_reg[DETW-1];
            end
        end
    end

    // Divider state, one slot per stage: slot 0 is the seed written by
    // stage 6, slot s+1 is the result of divider step s.
    logic [RW-1:0]   rem_reg  [QB+1][NENT];
    logic [QB-1:0]   quo_reg  [QB+1][NENT];
    logic [QB-1:0]   nlo_reg  [QB+1][NENT];
    logic [DETW-1:0] dmag_reg [QB+1];
    logic [NENT-1:0] neg_reg  [QB+1];
    logic [NENT-1:0] ovf_reg  [QB+1];
    logic            zero_reg [QB+1];

    // Stage 6: the numerator is |adj| shifted up by twice the fraction bits.
    // Its part above the quotient field seeds the remainder; if that part
    // already reaches the divisor, the quotient cannot fit and saturates.
    logic [NW-1:0] num [NENT];
    logic [NW-1:0] num_hi [NENT];

    always_comb
    begin
        for (int k = 0; k < NENT; k++)
        begin
            num[k]    = NW'(amag_reg[k]) << (2 * FB);
            num_hi[k] = num[k] >> QB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_DIV])
        begin
            for (int k = 0; k < NENT; k++)
            begin
                rem_reg[0][k] <= RW'(num_hi[k]);
                quo_reg[0][k] <= '0;
                nlo_reg[0][k] <= num[k][QB-1:0];
                ovf_reg[0][k] <= (XW'(num_hi[k]) >= XW'(dmag5_reg));
            end
            dmag_reg[0] <= dmag5_reg;
            neg_reg[0]  <= neg5_reg;
            zero_reg[0] <= zero5_reg;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        logic [RW-1:0] rs [NENT];
        logic [NENT-1:0] ge;

        always_comb
        begin
            for (int k = 0; k < NENT; k++)
            begin
                rs[k] = {rem_reg[s][k][RW-2:0], nlo_reg[s][k][QB-1-s]};
                ge[k] = (rs[k] >= RW'(dmag_reg[s]));
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[S_DIV+1+s])
            begin
                for (int k = 0; k < NENT; k++)
                begin
                    rem_reg[s+1][k] <= ge[k] ? rs[k] - RW'(dmag_reg[s]) : rs[k];
                    quo_reg[s+1][k] <= {quo_reg[s][k][QB-2:0], ge[k]};
                end
                nlo_reg[s+1]  <= nlo_reg[s];
                dmag_reg[s+1] <= dmag_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    // Rounding: add one when twice the remainder reaches the divisor, which
    // rounds ties away from zero on the magnitude.
    logic [QW-1:0]   qr_reg [NENT];
    logic [NENT-1:0] negr_reg;
    logic [NENT-1:0] ovfr_reg;
    logic            zeror_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_RND])
        begin
            for (int k = 0; k < NENT; k++)
            begin
                qr_reg[k] <= QW'(quo_reg[QB][k])
                           + QW'({rem_reg[QB][k][RW-2:0], 1'b0} >= RW'(dmag_reg[QB]));
            end
            negr_reg  <= neg_reg[QB];
            ovfr_reg  <= ovf_reg[QB];
            zeror_reg <= zero_reg[QB];
        end
    end

    // Output stage: saturate to the signed range, apply the sign, and force
    // zeros for a singular block.
    logic [QW-1:0]   lim  [NENT];
    logic [QW-1:0]   mag  [NENT];
    logic [DW-1:0]   res  [NENT];
    logic [DW-1:0]   res_reg [NENT];
    logic            sing_reg;

    always_comb
    begin
        for (int k = 0; k < NENT; k++)
        begin
            lim[k] = negr_reg[k] ? (QW'(1) << (DW - 1))
                                 : (QW'(1) << (DW - 1)) - QW'(1);
            mag[k] = (ovfr_reg[k] || (qr_reg[k] > lim[k])) ? lim[k] : qr_reg[k];
            if (zeror_reg)
            begin
                res[k] = '0;
            end
            else if (negr_reg[k])
            begin
                res[k] = DW'(-mag[k]);
            end
            else
            begin
                res[k] = DW'(mag[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_OUT])
        begin
            res_reg  <= res;
            sing_reg <= zeror_reg;
        end
    end

    always_comb
    begin
        inv_data.r00      = res_reg[0];
        inv_data.r01      = res_reg[1];
        inv_data.r02      = res_reg[2];
        inv_data.r10      = res_reg[3];
        inv_data.r11      = res_reg[4];
        inv_data.r12      = res_reg[5];
        inv_data.r20      = res_reg[6];
        inv_data.r21      = res_reg[7];
        inv_data.r22      = res_reg[8];
        inv_data.singular = sing_reg;
    end

endmodule
